// ===== sv/gdfw_pkg.sv =====
// Shared types, constants and command codes for the depth-first walk core.
// Used by the controller, the datapath and the top level; depends on nothing.
package gdfw_pkg;

   // Graph size limits.
   localparam int MAX_VERTICES = 32;
   localparam int MAX_DEGREE   = 8;

   // Field widths of the request and response.
   localparam int VTX_W   = 5;
   localparam int VCNT_W  = 6;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 2;

   // Derived storage widths.
   localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
   localparam int DEPTH_W   = $clog2(MAX_VERTICES + 1);
   localparam int NBR_DEPTH = MAX_VERTICES * MAX_DEGREE;
   localparam int ADDR_W    = $clog2(NBR_DEPTH);

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_ADD_VERTEX = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD_EDGE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WALK       = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE       = 2'd3;

   // Response status codes.
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADVERTEX = 2'd2;
   localparam logic [STAT_W-1:0] ST_LISTFULL  = 2'd3;

   // One request.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [VTX_W-1:0]  from_vertex;
      logic [VTX_W-1:0]  to_vertex;
      logic [VTX_W-1:0]  start_vertex;
   } req_type;

   // One response.
   typedef struct packed {
      logic [VTX_W-1:0]  visited_vertex;
      logic [VCNT_W-1:0] vertex_count;
      logic [STAT_W-1:0] status;
      logic              last;
   } rsp_type;

   // Datapath commands issued by the controller.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_ADD_VERTEX,
      CMD_ADD_EDGE,
      CMD_WALK_START,
      CMD_WALK_REJECT,
      CMD_STEP,
      CMD_CHECK
   } dp_cmd_type;

   // Datapath status returned to the controller.
   typedef struct packed {
      logic start_ok;
      logic pos_zero;
      logic last_level;
   } dp_status_type;

endpackage

// ===== sv/gdfw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds no reset and no package dependency.
module gdfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gdfw_datapath.sv =====
// Datapath of the depth-first walk core: vertex count, list lengths, visited
// marks, walk stack, neighbor memory and the response register. Uses gdfw_pkg
// and gdfw_ram.
module gdfw_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  gdfw_pkg::dp_cmd_type    cmd,
   input  gdfw_pkg::req_type       req_data,
   output gdfw_pkg::dp_status_type status,
   output logic                    rsp_valid,
   output gdfw_pkg::rsp_type       rsp_data
);

   // Control state.
   logic [gdfw_pkg::VCNT_W-1:0]                                vertex_total_ff, total_in;
   logic [gdfw_pkg::MAX_VERTICES-1:0][gdfw_pkg::DEG_W-1:0]     degree_ff;
   logic [gdfw_pkg::MAX_VERTICES-1:0]                          visited_ff;
   logic [gdfw_pkg::DEPTH_W-1:0]                               depth_ff, depth_in;
   logic                                                       rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [gdfw_pkg::VTX_W-1:0] stack_vtx_ff [gdfw_pkg::MAX_VERTICES];
   logic [gdfw_pkg::DEG_W-1:0] stack_pos_ff [gdfw_pkg::MAX_VERTICES];
   logic [gdfw_pkg::VTX_W-1:0] pending_ff, pending_in;
   gdfw_pkg::rsp_type          rsp_ff, rsp_in;

   // Working signals.
   logic [gdfw_pkg::DEPTH_W-1:0] depth_dec;
   logic [gdfw_pkg::VTX_W-1:0]   top_idx;
   logic [gdfw_pkg::VTX_W-1:0]   top_vtx;
   logic [gdfw_pkg::DEG_W-1:0]   top_pos;
   logic [gdfw_pkg::VTX_W-1:0]   nbr_rd_data;
   logic [gdfw_pkg::VTX_W-1:0]   deg_addr;
   logic [gdfw_pkg::DEG_W-1:0]   deg_rd;
   logic [gdfw_pkg::ADDR_W-1:0]  nbr_wr_addr, nbr_rd_addr;
   logic                         edge_ok, list_full, fresh;
   logic                         edge_wr, nbr_rd, push, pos_dec, walk_init;

   // Top of the walk stack.
   assign depth_dec = depth_ff - gdfw_pkg::DEPTH_W'(1);
   assign top_idx   = depth_dec[gdfw_pkg::VTX_W-1:0];
   assign top_vtx   = stack_vtx_ff[top_idx];
   assign top_pos   = stack_pos_ff[top_idx];

   // The list-length table has one read port whose address follows the command.
   always_comb begin
      unique case (cmd)
         gdfw_pkg::CMD_ADD_EDGE:   deg_addr = req_data.from_vertex;
         gdfw_pkg::CMD_WALK_START: deg_addr = req_data.start_vertex;
         default:                  deg_addr = nbr_rd_data;
      endcase
   end
   assign deg_rd = degree_ff[deg_addr];

   // Request checks.
   assign edge_ok = (gdfw_pkg::VCNT_W'(req_data.from_vertex) < vertex_total_ff) &&
                    (gdfw_pkg::VCNT_W'(req_data.to_vertex) < vertex_total_ff);
   assign list_full = deg_rd >= gdfw_pkg::DEG_W'(gdfw_pkg::MAX_DEGREE);
   assign fresh     = !visited_ff[nbr_rd_data] &&
                      (depth_ff < gdfw_pkg::DEPTH_W'(gdfw_pkg::MAX_VERTICES));

   // Neighbor memory addresses: the new edge goes after the existing ones, and
   // the walk reads the list from its end, so the newest edge is taken first.
   assign nbr_wr_addr = gdfw_pkg::ADDR_W'(req_data.from_vertex) *
                        gdfw_pkg::ADDR_W'(gdfw_pkg::MAX_DEGREE) +
                        gdfw_pkg::ADDR_W'(deg_rd);
   assign nbr_rd_addr = gdfw_pkg::ADDR_W'(top_vtx) *
                        gdfw_pkg::ADDR_W'(gdfw_pkg::MAX_DEGREE) +
                        gdfw_pkg::ADDR_W'(top_pos - gdfw_pkg::DEG_W'(1));

   // Status to the controller.
   assign status.start_ok   = gdfw_pkg::VCNT_W'(req_data.start_vertex) < vertex_total_ff;
   assign status.pos_zero   = (top_pos == '0);
   assign status.last_level = (depth_ff == gdfw_pkg::DEPTH_W'(1));

   // Next-state logic for each command. The walk holds one visited vertex back
   // until it knows whether another follows, so the final one carries last.
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = '{visited_vertex: '0, vertex_count: vertex_total_ff,
                       status: gdfw_pkg::ST_OK, last: 1'b1};
      total_in     = vertex_total_ff;
      depth_in     = depth_ff;
      pending_in   = pending_ff;
      edge_wr      = 1'b0;
      nbr_rd       = 1'b0;
      push         = 1'b0;
      pos_dec      = 1'b0;
      walk_init    = 1'b0;
      unique case (cmd)
         gdfw_pkg::CMD_NONE: begin
         end
         gdfw_pkg::CMD_ADD_VERTEX: begin
            rsp_valid_in = 1'b1;
            if (vertex_total_ff >= gdfw_pkg::VCNT_W'(gdfw_pkg::MAX_VERTICES)) begin
               rsp_in.status = gdfw_pkg::ST_OVERFLOW;
            end else begin
               total_in            = vertex_total_ff + gdfw_pkg::VCNT_W'(1);
               rsp_in.vertex_count = total_in;
            end
         end
         gdfw_pkg::CMD_ADD_EDGE: begin
            rsp_valid_in = 1'b1;
            if (!edge_ok) begin
               rsp_in.status = gdfw_pkg::ST_BADVERTEX;
            end else if (list_full) begin
               rsp_in.status = gdfw_pkg::ST_LISTFULL;
            end else begin
               edge_wr = 1'b1;
            end
         end
         gdfw_pkg::CMD_WALK_START: begin
            walk_init  = 1'b1;
            depth_in   = gdfw_pkg::DEPTH_W'(1);
            pending_in = req_data.start_vertex;
         end
         gdfw_pkg::CMD_WALK_REJECT: begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = gdfw_pkg::ST_BADVERTEX;
         end
         gdfw_pkg::CMD_STEP: begin
            if (status.pos_zero) begin
               depth_in = depth_dec;
               if (status.last_level) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.visited_vertex = pending_ff;
               end
            end else begin
               pos_dec = 1'b1;
               nbr_rd  = 1'b1;
            end
         end
         gdfw_pkg::CMD_CHECK: begin
            if (fresh) begin
               push                  = 1'b1;
               depth_in              = depth_ff + gdfw_pkg::DEPTH_W'(1);
               rsp_valid_in          = 1'b1;
               rsp_in.visited_vertex = pending_ff;
               rsp_in.last           = 1'b0;
               pending_in            = nbr_rd_data;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_total_ff <= '0;
         degree_ff       <= '0;
         visited_ff      <= '0;
         depth_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         vertex_total_ff <= total_in;
         depth_ff        <= depth_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (edge_wr) begin
            degree_ff[req_data.from_vertex] <= deg_rd + gdfw_pkg::DEG_W'(1);
         end
         if (walk_init) begin
            visited_ff <= {{(gdfw_pkg::MAX_VERTICES-1){1'b0}}, 1'b1} << req_data.start_vertex;
         end else if (push) begin
            visited_ff[nbr_rd_data] <= 1'b1;
         end
      end
   end

   // Payload registers: walk stack, held-back vertex and response.
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      pending_ff <= pending_in;
      if (walk_init) begin
         stack_vtx_ff[0] <= req_data.start_vertex;
         stack_pos_ff[0] <= deg_rd;
      end
      if (pos_dec) begin
         stack_pos_ff[top_idx] <= top_pos - gdfw_pkg::DEG_W'(1);
      end
      if (push) begin
         stack_vtx_ff[depth_ff[gdfw_pkg::VTX_W-1:0]] <= nbr_rd_data;
         stack_pos_ff[depth_ff[gdfw_pkg::VTX_W-1:0]] <= deg_rd;
      end
   end

   // Neighbor lists, one row of MAX_DEGREE slots per vertex.
   gdfw_ram #(
      .WIDTH (gdfw_pkg::VTX_W),
      .DEPTH (gdfw_pkg::NBR_DEPTH)
   ) u_nbr_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (nbr_wr_addr),
      .wr_data (req_data.to_vertex),
      .rd_en   (nbr_rd),
      .rd_addr (nbr_rd_addr),
      .rd_data (nbr_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The stack never grows past one level per vertex.
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= gdfw_pkg::DEPTH_W'(gdfw_pkg::MAX_VERTICES))
      else $error("walk stack deeper than the vertex limit");

   // The vertex count stays within the graph limit.
   assert property (@(posedge clock) disable iff (reset)
      vertex_total_ff <= gdfw_pkg::VCNT_W'(gdfw_pkg::MAX_VERTICES))
      else $error("vertex count above the graph limit");

   // Only walk results that are followed by more results have last low.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> (rsp_ff.status == gdfw_pkg::ST_OK))
      else $error("non-final response carries an error status");

endmodule

// ===== sv/gdfw_controller.sv =====
// Controller of the depth-first walk core: decodes requests and sequences the
// walk over the datapath. Uses gdfw_pkg for command and status types.
module gdfw_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [gdfw_pkg::FUNC_W-1:0]        req_func,
   input  gdfw_pkg::dp_status_type            status,
   output gdfw_pkg::dp_cmd_type               cmd,
   output logic                               busy
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_STEP  = 3'b010,
      S_CHECK = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Request decode and walk sequencing: STEP looks at the stack top and
   // either pops it or fetches its next neighbor; CHECK examines that neighbor.
   always_comb begin
      state_in = state_ff;
      cmd      = gdfw_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_func)
                  gdfw_pkg::FUNC_ADD_VERTEX: cmd = gdfw_pkg::CMD_ADD_VERTEX;
                  gdfw_pkg::FUNC_ADD_EDGE:   cmd = gdfw_pkg::CMD_ADD_EDGE;
                  gdfw_pkg::FUNC_WALK: begin
                     if (status.start_ok) begin
                        cmd      = gdfw_pkg::CMD_WALK_START;
                        state_in = S_STEP;
                     end else begin
                        cmd = gdfw_pkg::CMD_WALK_REJECT;
                     end
                  end
                  gdfw_pkg::FUNC_NONE:       cmd = gdfw_pkg::CMD_NONE;
                  default:                   cmd = gdfw_pkg::CMD_NONE;
               endcase
            end
         end
         S_STEP: begin
            cmd = gdfw_pkg::CMD_STEP;
            if (status.pos_zero) begin
               if (status.last_level) begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd      = gdfw_pkg::CMD_CHECK;
            state_in = S_STEP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // Exactly one state bit is set.
   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

   // A neighbor is examined only right after it was fetched.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ($past(state_ff) == S_STEP))
      else $error("neighbor check without a preceding fetch");

   // A walk ends only by popping the bottom stack level.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff) != S_IDLE) |->
      ($past(state_ff) == S_STEP && $past(status.pos_zero) && $past(status.last_level)))
      else $error("walk ended before the stack emptied");

endmodule

// ===== sv/graph_depth_first_walk_core.sv =====
// Add vertex, add edge and a rejected walk each give one response in the cycle
// after the request is taken, and these requests may follow every cycle.
// A walk holds busy after it is taken until the stack loop pops the bottom level;
// each step of the loop is a neighbor fetch, a check of that neighbor or a pop,
// with the neighbor memory read registered between fetch and check.
// Synchronous reset empties the graph; the neighbor memory is not cleared.
module graph_depth_first_walk_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gdfw_pkg::req_type req_data,
   output logic              rsp_valid,
   output gdfw_pkg::rsp_type rsp_data
);

   gdfw_pkg::dp_cmd_type    dp_cmd;
   gdfw_pkg::dp_status_type dp_status;

   // Request decode and walk sequencing.
   gdfw_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .status   (dp_status),
      .cmd      (dp_cmd),
      .busy     (busy)
   );

   // Graph storage, walk stack and response register.
   gdfw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .req_data  (req_data),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
